// ===== src/limit_order_book_matcher_unit_macros.svh =====
// Assertion helpers for the order book matcher.
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LOBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lobm_pkg.sv =====
package lobm_pkg;

  localparam int ID_W    = 16;
  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;

  // Operation codes; code 3 behaves as run matching
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_MATCH  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FILL      = 3'd5;
  localparam logic [2:0] ST_NO_TRADE  = 3'd6;

  typedef struct packed {
    logic [1:0]         operation;
    logic [ID_W-1:0]    order_id;
    logic               side;
    logic [PRICE_W-1:0] limit_price;
    logic [QTY_W-1:0]   order_quantity;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ID_W-1:0]    bid_id;
    logic [ID_W-1:0]    ask_id;
    logic [PRICE_W-1:0] trade_price;
    logic [QTY_W-1:0]   trade_quantity;
    logic               bid_closed;
    logic               ask_closed;
    logic               last_result;
    logic [PRICE_W-1:0] best_bid_price;
    logic [QTY_W-1:0]   best_bid_size;
    logic [PRICE_W-1:0] best_ask_price;
    logic [QTY_W-1:0]   best_ask_size;
  } out_t;

  // One resting order
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } entry_t;

  // One recorded fill, held until the step's best levels are known
  typedef struct packed {
    logic [ID_W-1:0]    bid_id;
    logic [ID_W-1:0]    ask_id;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic               bid_closed;
    logic               ask_closed;
  } fill_t;

endpackage

// ===== src/limit_order_book_matcher_unit.sv =====
// Price-time limit order book: a bid side and an ask side, each a single RAM of
// BOOK_DEPTH orders kept sorted, walked by one sequencer one entry at a time.
// An insert or cancel scans entries, moves entries and walks the entries at
// the best levels; a match crosses the heads once per fill, moves entries
// when a head order closes, then makes the best-level pass, then delivers
// the fills. Fills are buffered in a RAM of 2*BOOK_DEPTH-1 entries so that
// every result can carry the final best levels. The input is not ready from
// acceptance until the last result is taken by the output register.
module limit_order_book_matcher_unit #(
  parameter int BOOK_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lobm_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lobm_pkg::out_t  out_data
);
  import lobm_pkg::*;

  localparam int AW  = $clog2(BOOK_DEPTH);
  localparam int FD  = 2 * BOOK_DEPTH - 1;
  localparam int FAW = $clog2(FD);

  logic           bid_we, ask_we, fill_we;
  logic [AW-1:0]  bid_waddr, bid_raddr, ask_waddr, ask_raddr;
  entry_t         bid_wdata, bid_rdata, ask_wdata, ask_rdata;
  logic [FAW-1:0] fill_waddr, fill_raddr;
  fill_t          fill_wdata, fill_rdata;
  logic           res_valid, res_ready;
  out_t           res_data;
  logic           out_valid_r;
  out_t           out_data_r;

  lobm_ram #(.DEPTH(BOOK_DEPTH), .WIDTH($bits(entry_t))) u_bid_ram (
    .clk(clk), .wr_en(bid_we), .wr_addr(bid_waddr), .wr_data(bid_wdata),
    .rd_addr(bid_raddr), .rd_data(bid_rdata)
  );

  lobm_ram #(.DEPTH(BOOK_DEPTH), .WIDTH($bits(entry_t))) u_ask_ram (
    .clk(clk), .wr_en(ask_we), .wr_addr(ask_waddr), .wr_data(ask_wdata),
    .rd_addr(ask_raddr), .rd_data(ask_rdata)
  );

  lobm_ram #(.DEPTH(FD), .WIDTH($bits(fill_t))) u_fill_ram (
    .clk(clk), .wr_en(fill_we), .wr_addr(fill_waddr), .wr_data(fill_wdata),
    .rd_addr(fill_raddr), .rd_data(fill_rdata)
  );

  lobm_seq #(.BOOK_DEPTH(BOOK_DEPTH)) u_seq (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .bid_we(bid_we), .bid_waddr(bid_waddr), .bid_wdata(bid_wdata),
    .bid_raddr(bid_raddr), .bid_rdata(bid_rdata),
    .ask_we(ask_we), .ask_waddr(ask_waddr), .ask_wdata(ask_wdata),
    .ask_raddr(ask_raddr), .ask_rdata(ask_rdata),
    .fill_we(fill_we), .fill_waddr(fill_waddr), .fill_wdata(fill_wdata),
    .fill_raddr(fill_raddr), .fill_rdata(fill_rdata),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
  );

  // Hold one result in the output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/lobm_ram.sv =====
module lobm_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 80
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/lobm_seq.sv =====
module lobm_seq #(
  parameter int BOOK_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  lobm_pkg::in_t                      in_data,
  output logic                               bid_we,
  output logic [$clog2(BOOK_DEPTH)-1:0]      bid_waddr,
  output lobm_pkg::entry_t                   bid_wdata,
  output logic [$clog2(BOOK_DEPTH)-1:0]      bid_raddr,
  input  lobm_pkg::entry_t                   bid_rdata,
  output logic                               ask_we,
  output logic [$clog2(BOOK_DEPTH)-1:0]      ask_waddr,
  output lobm_pkg::entry_t                   ask_wdata,
  output logic [$clog2(BOOK_DEPTH)-1:0]      ask_raddr,
  input  lobm_pkg::entry_t                   ask_rdata,
  output logic                               fill_we,
  output logic [$clog2(2*BOOK_DEPTH-1)-1:0]  fill_waddr,
  output lobm_pkg::fill_t                    fill_wdata,
  output logic [$clog2(2*BOOK_DEPTH-1)-1:0]  fill_raddr,
  input  lobm_pkg::fill_t                    fill_rdata,
  output logic                               res_valid,
  input  logic                               res_ready,
  output lobm_pkg::out_t                     res_data
);
  import lobm_pkg::*;

`include "limit_order_book_matcher_unit_macros.svh"

  localparam int AW        = $clog2(BOOK_DEPTH);
  localparam int CW        = $clog2(BOOK_DEPTH + 1);
  localparam int MAX_FILLS = 2 * BOOK_DEPTH - 1;
  localparam int FAW       = $clog2(MAX_FILLS);
  localparam int FCW       = $clog2(MAX_FILLS + 1);
  localparam logic [CW-1:0]  DEPTH_C = CW'(BOOK_DEPTH);
  localparam logic [FCW-1:0] MAXF_C  = FCW'(MAX_FILLS);

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CK, S_DEC, S_INS_RD, S_INS_WR, S_INS_PUT,
    S_DRP_RD, S_DRP_WR, S_M_RD, S_M_CK, S_M_END, S_BEST, S_B_RD, S_B_CK,
    S_OUT, S_RES, S_F_RD, S_F_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic               side_r, side_nxt;
  logic [PRICE_W-1:0] price_r, price_nxt;
  logic [QTY_W-1:0]   qty_r, qty_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic               pos_set_r, pos_set_nxt;
  logic               hit_r, hit_nxt;
  logic [2:0]         status_r, status_nxt;
  logic [FCW-1:0]     nfill_r, nfill_nxt;
  logic [FCW-1:0]     kout_r, kout_nxt;
  logic               drop_ask_r, drop_ask_nxt;
  logic               acl_r, acl_nxt;
  logic [CW-1:0]      bid_cnt_r, bid_cnt_nxt;
  logic [CW-1:0]      ask_cnt_r, ask_cnt_nxt;
  logic [PRICE_W-1:0] bb_p_r, bb_p_nxt, ba_p_r, ba_p_nxt;
  logic [QTY_W-1:0]   bb_s_r, bb_s_nxt, ba_s_r, ba_s_nxt;
  logic               brun_r, brun_nxt, arun_r, arun_nxt;

  logic               is_cancel, is_insert;
  logic [CW-1:0]      own_cnt, scan_lim, idx_p1, drop_cnt;
  entry_t             own_rd;
  logic               bid_in, ask_in, own_in, ahead;
  logic [QTY_W-1:0]   trade_q;
  logic               bcl, acl;
  logic [QTY_W:0]     bsum, asum;
  logic               bgo, ago;

  assign is_insert = (op_r == OP_INSERT);
  assign is_cancel = (op_r == OP_CANCEL);
  assign own_cnt   = side_r ? ask_cnt_r : bid_cnt_r;
  assign own_rd    = side_r ? ask_rdata : bid_rdata;
  assign idx_p1    = idx_r + CW'(1);
  assign drop_cnt  = drop_ask_r ? ask_cnt_r : bid_cnt_r;
  assign bid_in    = idx_r < bid_cnt_r;
  assign ask_in    = idx_r < ask_cnt_r;
  assign own_in    = idx_r < own_cnt;
  assign ahead     = side_r ? (own_rd.price <= price_r) : (own_rd.price >= price_r);
  assign scan_lim  = is_cancel ? own_cnt :
                     ((bid_cnt_r > ask_cnt_r) ? bid_cnt_r : ask_cnt_r);

  // Shared compare and subtract for one fill
  assign trade_q = (bid_rdata.qty < ask_rdata.qty) ? bid_rdata.qty : ask_rdata.qty;
  assign bcl     = (bid_rdata.qty == trade_q);
  assign acl     = (ask_rdata.qty == trade_q);

  // Best-level accumulation, one entry of each side per step
  assign bgo  = brun_r && bid_in && ((idx_r == '0) || (bid_rdata.price == bb_p_r));
  assign ago  = arun_r && ask_in && ((idx_r == '0) || (ask_rdata.price == ba_p_r));
  assign bsum = {1'b0, bb_s_r} + {1'b0, bid_rdata.qty};
  assign asum = {1'b0, ba_s_r} + {1'b0, ask_rdata.qty};

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    side_nxt     = side_r;
    price_nxt    = price_r;
    qty_nxt      = qty_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    pos_set_nxt  = pos_set_r;
    hit_nxt      = hit_r;
    status_nxt   = status_r;
    nfill_nxt    = nfill_r;
    kout_nxt     = kout_r;
    drop_ask_nxt = drop_ask_r;
    acl_nxt      = acl_r;
    bid_cnt_nxt  = bid_cnt_r;
    ask_cnt_nxt  = ask_cnt_r;
    bb_p_nxt     = bb_p_r;
    bb_s_nxt     = bb_s_r;
    ba_p_nxt     = ba_p_r;
    ba_s_nxt     = ba_s_r;
    brun_nxt     = brun_r;
    arun_nxt     = arun_r;

    bid_we     = 1'b0;
    bid_waddr  = idx_r[AW-1:0];
    bid_wdata  = own_rd;
    bid_raddr  = idx_r[AW-1:0];
    ask_we     = 1'b0;
    ask_waddr  = idx_r[AW-1:0];
    ask_wdata  = own_rd;
    ask_raddr  = idx_r[AW-1:0];
    fill_we    = 1'b0;
    fill_waddr = nfill_r[FAW-1:0];
    fill_wdata = '{bid_id: bid_rdata.id, ask_id: ask_rdata.id, price: ask_rdata.price,
                   qty: trade_q, bid_closed: bcl, ask_closed: acl};
    fill_raddr = kout_r[FAW-1:0];
    res_valid  = 1'b0;
    res_data   = '0;
    res_data.best_bid_price = bb_p_r;
    res_data.best_bid_size  = bb_s_r;
    res_data.best_ask_price = ba_p_r;
    res_data.best_ask_size  = ba_s_r;

    unique case (state_r)
      // Latch the request and pick its sequence
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.operation;
          id_nxt      = in_data.order_id;
          side_nxt    = in_data.side;
          price_nxt   = in_data.limit_price;
          qty_nxt     = in_data.order_quantity;
          idx_nxt     = '0;
          pos_nxt     = in_data.side ? ask_cnt_r : bid_cnt_r;
          pos_set_nxt = 1'b0;
          hit_nxt     = 1'b0;
          nfill_nxt   = '0;
          acl_nxt     = 1'b0;
          if (in_data.operation == OP_INSERT || in_data.operation == OP_CANCEL) begin
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_M_RD;
          end
        end
      end
      // Walk the books for the id and the insert position
      S_SCAN_RD: begin
        if (idx_r >= scan_lim) begin
          state_nxt = S_DEC;
        end else begin
          state_nxt = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (is_insert) begin
          if ((bid_in && bid_rdata.id == id_r) || (ask_in && ask_rdata.id == id_r)) begin
            hit_nxt = 1'b1;
          end
          if (own_in && !ahead && !pos_set_r) begin
            pos_nxt     = idx_r;
            pos_set_nxt = 1'b1;
          end
        end else if (own_in && own_rd.id == id_r) begin
          hit_nxt = 1'b1;
          pos_nxt = idx_r;
        end
        if (hit_nxt) begin
          state_nxt = S_DEC;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_DEC: begin
        if (is_insert) begin
          if (hit_r) begin
            status_nxt = ST_DUPLICATE;
            state_nxt  = S_BEST;
          end else if (own_cnt == DEPTH_C) begin
            status_nxt = ST_FULL;
            state_nxt  = S_BEST;
          end else begin
            status_nxt = ST_INSERTED;
            idx_nxt    = own_cnt - CW'(1);
            state_nxt  = (pos_r == own_cnt) ? S_INS_PUT : S_INS_RD;
          end
        end else if (hit_r) begin
          status_nxt   = ST_CANCELLED;
          drop_ask_nxt = side_r;
          idx_nxt      = pos_r;
          state_nxt    = S_DRP_RD;
        end else begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_BEST;
        end
      end
      // Shift entries up one place to open the insert slot
      S_INS_RD: begin
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        bid_we    = !side_r;
        ask_we    = side_r;
        bid_waddr = idx_p1[AW-1:0];
        ask_waddr = idx_p1[AW-1:0];
        if (idx_r == pos_r) begin
          state_nxt = S_INS_PUT;
        end else begin
          idx_nxt   = idx_r - CW'(1);
          state_nxt = S_INS_RD;
        end
      end
      S_INS_PUT: begin
        bid_we    = !side_r;
        ask_we    = side_r;
        bid_waddr = pos_r[AW-1:0];
        ask_waddr = pos_r[AW-1:0];
        bid_wdata = '{id: id_r, price: price_r, qty: qty_r};
        ask_wdata = '{id: id_r, price: price_r, qty: qty_r};
        if (side_r) begin
          ask_cnt_nxt = ask_cnt_r + CW'(1);
        end else begin
          bid_cnt_nxt = bid_cnt_r + CW'(1);
        end
        state_nxt = S_BEST;
      end
      // Shift entries down one place over the removed slot
      S_DRP_RD: begin
        bid_raddr = idx_p1[AW-1:0];
        ask_raddr = idx_p1[AW-1:0];
        if (idx_p1 >= drop_cnt) begin
          if (drop_ask_r) begin
            ask_cnt_nxt = ask_cnt_r - CW'(1);
          end else begin
            bid_cnt_nxt = bid_cnt_r - CW'(1);
          end
          if (is_cancel) begin
            state_nxt = S_BEST;
          end else if (!drop_ask_r && acl_r) begin
            drop_ask_nxt = 1'b1;
            idx_nxt      = '0;
            state_nxt    = S_DRP_RD;
          end else begin
            state_nxt = S_M_RD;
          end
        end else begin
          state_nxt = S_DRP_WR;
        end
      end
      S_DRP_WR: begin
        bid_we    = !drop_ask_r;
        ask_we    = drop_ask_r;
        bid_wdata = bid_rdata;
        ask_wdata = ask_rdata;
        idx_nxt   = idx_p1;
        state_nxt = S_DRP_RD;
      end
      // Cross the two heads while the book is crossed
      S_M_RD: begin
        bid_raddr = '0;
        ask_raddr = '0;
        if (bid_cnt_r == '0 || ask_cnt_r == '0 || nfill_r == MAXF_C) begin
          state_nxt = S_M_END;
        end else begin
          state_nxt = S_M_CK;
        end
      end
      S_M_CK: begin
        if (bid_rdata.price >= ask_rdata.price) begin
          bid_we    = 1'b1;
          ask_we    = 1'b1;
          bid_waddr = '0;
          ask_waddr = '0;
          bid_wdata = '{id: bid_rdata.id, price: bid_rdata.price,
                        qty: bid_rdata.qty - trade_q};
          ask_wdata = '{id: ask_rdata.id, price: ask_rdata.price,
                        qty: ask_rdata.qty - trade_q};
          fill_we   = 1'b1;
          nfill_nxt = nfill_r + FCW'(1);
          acl_nxt   = acl;
          idx_nxt   = '0;
          if (bcl) begin
            drop_ask_nxt = 1'b0;
            state_nxt    = S_DRP_RD;
          end else if (acl) begin
            drop_ask_nxt = 1'b1;
            state_nxt    = S_DRP_RD;
          end else begin
            state_nxt = S_M_RD;
          end
        end else begin
          state_nxt = S_M_END;
        end
      end
      S_M_END: begin
        status_nxt = (nfill_r == '0) ? ST_NO_TRADE : ST_FILL;
        state_nxt  = S_BEST;
      end
      // Sum the open quantity at the best price of each side
      S_BEST: begin
        idx_nxt  = '0;
        brun_nxt = (bid_cnt_r != '0);
        arun_nxt = (ask_cnt_r != '0);
        bb_p_nxt = '0;
        bb_s_nxt = '0;
        ba_p_nxt = '0;
        ba_s_nxt = '0;
        state_nxt = S_B_RD;
      end
      S_B_RD: begin
        state_nxt = (brun_r || arun_r) ? S_B_CK : S_OUT;
      end
      S_B_CK: begin
        brun_nxt = bgo;
        arun_nxt = ago;
        if (bgo) begin
          if (idx_r == '0) begin
            bb_p_nxt = bid_rdata.price;
          end
          bb_s_nxt = bsum[QTY_W] ? '1 : bsum[QTY_W-1:0];
        end
        if (ago) begin
          if (idx_r == '0) begin
            ba_p_nxt = ask_rdata.price;
          end
          ba_s_nxt = asum[QTY_W] ? '1 : asum[QTY_W-1:0];
        end
        idx_nxt   = idx_p1;
        state_nxt = S_B_RD;
      end
      S_OUT: begin
        kout_nxt  = '0;
        state_nxt = (status_r == ST_FILL) ? S_F_RD : S_RES;
      end
      // Deliver the single status result
      S_RES: begin
        res_valid            = 1'b1;
        res_data.status      = status_r;
        res_data.last_result = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      // Replay the recorded fills
      S_F_RD: begin
        state_nxt = S_F_OUT;
      end
      S_F_OUT: begin
        res_valid               = 1'b1;
        res_data.status         = ST_FILL;
        res_data.bid_id         = fill_rdata.bid_id;
        res_data.ask_id         = fill_rdata.ask_id;
        res_data.trade_price    = fill_rdata.price;
        res_data.trade_quantity = fill_rdata.qty;
        res_data.bid_closed     = fill_rdata.bid_closed;
        res_data.ask_closed     = fill_rdata.ask_closed;
        res_data.last_result    = (kout_r + FCW'(1) == nfill_r);
        if (res_ready) begin
          kout_nxt  = kout_r + FCW'(1);
          state_nxt = res_data.last_result ? S_IDLE : S_F_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bid_cnt_r <= '0;
      ask_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bid_cnt_r <= bid_cnt_nxt;
      ask_cnt_r <= ask_cnt_nxt;
    end
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    side_r     <= side_nxt;
    price_r    <= price_nxt;
    qty_r      <= qty_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    pos_set_r  <= pos_set_nxt;
    hit_r      <= hit_nxt;
    status_r   <= status_nxt;
    nfill_r    <= nfill_nxt;
    kout_r     <= kout_nxt;
    drop_ask_r <= drop_ask_nxt;
    acl_r      <= acl_nxt;
    bb_p_r     <= bb_p_nxt;
    bb_s_r     <= bb_s_nxt;
    ba_p_r     <= ba_p_nxt;
    ba_s_r     <= ba_s_nxt;
    brun_r     <= brun_nxt;
    arun_r     <= arun_nxt;
  end

  `LOBM_ASSERT_NOW(a_bid_cnt_max, 1'b1, bid_cnt_r <= DEPTH_C, "bid count over depth")
  `LOBM_ASSERT_NOW(a_ask_cnt_max, 1'b1, ask_cnt_r <= DEPTH_C, "ask count over depth")
  `LOBM_ASSERT_NOW(a_fill_closes, res_valid && res_data.status == ST_FILL, res_data.bid_closed || res_data.ask_closed, "fill closed neither order")
  `LOBM_ASSERT_NEXT(a_last_idle, res_valid && res_ready && res_data.last_result, in_ready, "not ready after last result")

endmodule

// ===== sim/limit_order_book_matcher_unit_tb.sv =====
`timescale 1ns / 100ps

module limit_order_book_matcher_unit_tb;
  import lobm_pkg::*;

  localparam int DEPTH      = 32;
  localparam int MAX_FILLS  = 2 * DEPTH - 1;
  localparam int CYCLE_CAP  = 20000000;
  localparam int DRAIN_WAIT = 600;
  localparam int HOLD_LEN   = 600;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Book model and expected results
  entry_t bid_book [DEPTH];
  entry_t ask_book [DEPTH];
  int     bid_cnt = 0;
  int     ask_cnt = 0;
  out_t   fresh_q[$];
  out_t   pending_q[$];

  int  cycles = 0;
  int  mismatches = 0;
  int  strays = 0;
  int  reqs_sent = 0;
  int  fills_seen = 0;
  int  results_seen = 0;
  int  fulls_seen = 0;
  int  dups_seen = 0;
  bit  hold_req = 1'b0;
  bit  draining = 1'b0;
  vector_t vectors[$];

  always #2 clk = ~clk;

  limit_order_book_matcher_unit #(.BOOK_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  function automatic int find_order(bit sd, logic [ID_W-1:0] id);
    for (int i = 0; i < DEPTH; i++) begin
      if (sd == 1'b0 && i < bid_cnt && bid_book[i].id == id) return i;
      if (sd == 1'b1 && i < ask_cnt && ask_book[i].id == id) return i;
    end
    return -1;
  endfunction

  function automatic void remove_order(bit sd, int idx);
    if (sd == 1'b0) begin
      for (int i = idx; i < bid_cnt - 1; i++) bid_book[i] = bid_book[i+1];
      bid_cnt--;
    end else begin
      for (int i = idx; i < ask_cnt - 1; i++) ask_book[i] = ask_book[i+1];
      ask_cnt--;
    end
  endfunction

  // Rest behind every order at an equal or better price
  function automatic void rest_order(bit sd, entry_t e);
    int pos;
    pos = 0;
    if (sd == 1'b0) begin
      while (pos < bid_cnt && bid_book[pos].price >= e.price) pos++;
      for (int i = bid_cnt; i > pos; i--) bid_book[i] = bid_book[i-1];
      bid_book[pos] = e;
      bid_cnt++;
    end else begin
      while (pos < ask_cnt && ask_book[pos].price <= e.price) pos++;
      for (int i = ask_cnt; i > pos; i--) ask_book[i] = ask_book[i-1];
      ask_book[pos] = e;
      ask_cnt++;
    end
  endfunction

  // Sum open quantity at the head price, saturating
  function automatic logic [QTY_W-1:0] head_size(bit sd);
    logic [QTY_W:0] sum;
    entry_t e;
    int n;
    sum = '0;
    n = sd ? ask_cnt : bid_cnt;
    for (int i = 0; i < n; i++) begin
      e = sd ? ask_book[i] : bid_book[i];
      if (e.price != (sd ? ask_book[0].price : bid_book[0].price)) break;
      sum = sum + e.qty;
      if (sum[QTY_W]) sum = {1'b0, {QTY_W{1'b1}}};
    end
    return sum[QTY_W-1:0];
  endfunction

  // Apply one request to the book and queue the results it causes
  function automatic void predict_book(in_t r);
    out_t   o;
    entry_t e;
    logic [QTY_W-1:0] t;
    int idx;
    int n;
    fresh_q.delete();
    o = '0;
    if (r.operation == OP_INSERT) begin
      if (find_order(1'b0, r.order_id) >= 0 || find_order(1'b1, r.order_id) >= 0)
        o.status = ST_DUPLICATE;
      else if ((r.side ? ask_cnt : bid_cnt) >= DEPTH)
        o.status = ST_FULL;
      else begin
        o.status = ST_INSERTED;
        e.id = r.order_id;
        e.price = r.limit_price;
        e.qty = r.order_quantity;
        rest_order(r.side, e);
      end
      fresh_q.push_back(o);
    end else if (r.operation == OP_CANCEL) begin
      idx = find_order(r.side, r.order_id);
      o.status = ST_NOT_FOUND;
      if (idx >= 0) begin
        remove_order(r.side, idx);
        o.status = ST_CANCELLED;
      end
      fresh_q.push_back(o);
    end else begin
      n = 0;
      while (bid_cnt > 0 && ask_cnt > 0 && n < MAX_FILLS &&
             bid_book[0].price >= ask_book[0].price) begin
        t = (bid_book[0].qty < ask_book[0].qty) ? bid_book[0].qty : ask_book[0].qty;
        bid_book[0].qty -= t;
        ask_book[0].qty -= t;
        o = '0;
        o.status = ST_FILL;
        o.bid_id = bid_book[0].id;
        o.ask_id = ask_book[0].id;
        o.trade_price = ask_book[0].price;
        o.trade_quantity = t;
        o.bid_closed = (bid_book[0].qty == '0);
        o.ask_closed = (ask_book[0].qty == '0);
        if (o.bid_closed) remove_order(1'b0, 0);
        if (o.ask_closed) remove_order(1'b1, 0);
        fresh_q.push_back(o);
        n++;
      end
      if (n == 0) begin
        o = '0;
        o.status = ST_NO_TRADE;
        fresh_q.push_back(o);
      end
    end
    foreach (fresh_q[k]) begin
      fresh_q[k].last_result = (k == fresh_q.size() - 1);
      fresh_q[k].best_bid_price = bid_cnt ? bid_book[0].price : '0;
      fresh_q[k].best_bid_size  = bid_cnt ? head_size(1'b0) : '0;
      fresh_q[k].best_ask_price = ask_cnt ? ask_book[0].price : '0;
      fresh_q[k].best_ask_size  = ask_cnt ? head_size(1'b1) : '0;
    end
  endfunction

  function automatic in_t make_req(logic [1:0] op, logic [ID_W-1:0] id, bit sd,
                                   logic [PRICE_W-1:0] px, logic [QTY_W-1:0] q);
    in_t r;
    r.operation = op;
    r.order_id = id;
    r.side = sd;
    r.limit_price = px;
    r.order_quantity = q;
    return r;
  endfunction

  function automatic void add_vector(in_t r, bit typed, out_t w);
    vector_t v;
    v.req = r;
    v.typed = typed;
    v.want = w;
    vectors.push_back(v);
  endfunction

  // Random request with content drawn toward crossing prices and reused ids
  function automatic in_t random_req();
    int sel;
    logic [1:0] op;
    logic [ID_W-1:0] id;
    logic [PRICE_W-1:0] px;
    logic [QTY_W-1:0] q;
    sel = $urandom_range(0, 99);
    op = (sel < 50) ? OP_INSERT : (sel < 75) ? OP_CANCEL : (sel < 95) ? OP_MATCH : 2'd3;
    id = ($urandom_range(0, 15) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 47));
    px = ($urandom_range(0, 15) == 0) ? $urandom : 32'd1000 + $urandom_range(0, 20);
    sel = $urandom_range(0, 39);
    q = (sel == 0) ? '0 : (sel == 1) ? '1 : (sel < 4) ? $urandom : $urandom_range(1, 100);
    return make_req(op, id, $urandom_range(0, 1), px, q);
  endfunction

  // Offer one request, hold it until accepted, then predict it
  task automatic send_req(in_t r, bit typed, out_t w);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = r;
    do @(posedge clk); while (!in_ready);
    predict_book(r);
    if (typed) pending_q.push_back(w);
    else foreach (fresh_q[k]) pending_q.push_back(fresh_q[k]);
    reqs_sent++;
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_valid = 1'b0;
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got, inout bit bad);
    if (want !== got) begin
      if (mismatches < 10)
        $display("  %s: expected %h, got %h (result %0d)", name, want, got, results_seen);
      bad = 1'b1;
    end
  endtask

  // Receiver: random back-pressure, with one long hold on request
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        for (int c = 0; c < HOLD_LEN; c++) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = ($urandom_range(0, 9) < 6 || draining) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    bit bad;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        strays++;
        if (strays <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = pending_q.pop_front();
        bad = 1'b0;
        check_field("status", want.status, out_data.status, bad);
        check_field("bid_id", want.bid_id, out_data.bid_id, bad);
        check_field("ask_id", want.ask_id, out_data.ask_id, bad);
        check_field("trade_price", want.trade_price, out_data.trade_price, bad);
        check_field("trade_quantity", want.trade_quantity, out_data.trade_quantity, bad);
        check_field("bid_closed", want.bid_closed, out_data.bid_closed, bad);
        check_field("ask_closed", want.ask_closed, out_data.ask_closed, bad);
        check_field("last_result", want.last_result, out_data.last_result, bad);
        check_field("best_bid_price", want.best_bid_price, out_data.best_bid_price, bad);
        check_field("best_bid_size", want.best_bid_size, out_data.best_bid_size, bad);
        check_field("best_ask_price", want.best_ask_price, out_data.best_ask_price, bad);
        check_field("best_ask_size", want.best_ask_size, out_data.best_ask_size, bad);
        if (bad) mismatches++;
        if (want.status == ST_FILL) fills_seen++;
        if (want.status == ST_FULL) fulls_seen++;
        if (want.status == ST_DUPLICATE) dups_seen++;
      end
      results_seen++;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("limit_order_book_matcher_unit: mismatch");
      $finish;
    end
  end

  initial begin
    out_t w;
    out_t none;
    int base;
    int fails;
    none = '0;

    // Directed: empty book, extremes, and special cases other than a full side
    w = '0; w.status = ST_NO_TRADE; w.last_result = 1'b1;
    add_vector(make_req(OP_MATCH, 16'd0, 1'b0, '0, '0), 1'b1, w);
    w = '0; w.status = ST_NOT_FOUND; w.last_result = 1'b1;
    add_vector(make_req(OP_CANCEL, 16'd5, 1'b1, '0, '0), 1'b1, w);
    w = '0; w.status = ST_INSERTED; w.last_result = 1'b1;
    w.best_bid_price = '1; w.best_bid_size = '1;
    add_vector(make_req(OP_INSERT, 16'd1, 1'b0, '1, '1), 1'b1, w);
    add_vector(make_req(OP_INSERT, 16'd2, 1'b0, '1, 32'd7), 1'b0, none);
    add_vector(make_req(OP_INSERT, 16'd1, 1'b1, 32'd5, 32'd5), 1'b0, none);
    add_vector(make_req(OP_CANCEL, 16'd2, 1'b1, '0, '0), 1'b0, none);
    add_vector(make_req(OP_INSERT, 16'hffff, 1'b1, '0, '0), 1'b0, none);
    add_vector(make_req(2'd3, 16'hffff, 1'b1, '1, '1), 1'b0, none);
    add_vector(make_req(OP_INSERT, 16'd4, 1'b1, 32'd0, 32'd5), 1'b0, none);
    add_vector(make_req(OP_INSERT, 16'd6, 1'b1, 32'd9, '1), 1'b0, none);
    add_vector(make_req(OP_MATCH, 16'd0, 1'b0, '0, '0), 1'b0, none);
    add_vector(make_req(OP_CANCEL, 16'd2, 1'b0, '0, '0), 1'b0, none);
    add_vector(make_req(OP_CANCEL, 16'd1, 1'b0, '0, '0), 1'b0, none);
    add_vector(make_req(OP_INSERT, 16'd8, 1'b0, 32'd8, 32'd3), 1'b0, none);
    add_vector(make_req(OP_INSERT, 16'd9, 1'b0, 32'd8, 32'd4), 1'b0, none);
    add_vector(make_req(OP_MATCH, 16'd0, 1'b0, '0, '0), 1'b0, none);
    add_vector(make_req(OP_INSERT, 16'd10, 1'b1, 32'd8, 32'd20), 1'b0, none);
    add_vector(make_req(OP_MATCH, 16'd0, 1'b1, '0, '0), 1'b0, none);
    add_vector(make_req(OP_CANCEL, 16'd6, 1'b1, '0, '0), 1'b0, none);
    add_vector(make_req(OP_CANCEL, 16'd10, 1'b1, '0, '0), 1'b0, none);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (vectors[i]) send_req(vectors[i].req, vectors[i].typed, vectors[i].want);

    // Random: mostly reused ids and crossing prices, with side-filling bursts
    for (int n = 0; n < 280; n++) begin
      if (n == 120) hold_req = 1'b1;
      if (n == 240) begin
        idle_input();
        wait (pending_q.size() == 0);
        @(negedge clk);
      end
      if (n % 100 == 50) begin
        // Fill one side past its depth, trade through it, then clear it
        base = 16'h4000 + n * 64;
        w[0] = $urandom_range(0, 1);
        for (int k = 0; k < DEPTH + 2; k++)
          send_req(make_req(OP_INSERT, ID_W'(base + k), w[0],
                            32'd995 + $urandom_range(0, 30), $urandom_range(0, 40)), 1'b0, none);
        for (int k = 0; k < 6; k++)
          send_req(make_req(OP_INSERT, ID_W'(base + 40 + k), ~w[0],
                            32'd995 + $urandom_range(0, 30), $urandom_range(1, 400)), 1'b0, none);
        send_req(make_req(OP_MATCH, 16'd0, 1'b0, '0, '0), 1'b0, none);
        for (int k = 0; k < DEPTH + 2; k++)
          send_req(make_req(OP_CANCEL, ID_W'(base + k), w[0], '0, '0), 1'b0, none);
      end
      send_req(random_req(), 1'b0, none);
    end
    idle_input();

    // Drain, then watch for extra results
    draining = 1'b1;
    wait (pending_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    fails = mismatches + strays + pending_q.size();
    $display("%0d requests, %0d results: %0d fills, %0d full-side and %0d duplicate rejects",
             reqs_sent, results_seen, fills_seen, fulls_seen, dups_seen);
    $display("%0d mismatched, %0d unexpected, %0d missing results",
             mismatches, strays, pending_q.size());
    if (fails == 0) begin
      $display("limit_order_book_matcher_unit: match");
    end else begin
      $display("limit_order_book_matcher_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== limit_order_book_matcher_unit.f =====
+incdir+src
src/lobm_pkg.sv
src/lobm_ram.sv
src/lobm_seq.sv
src/limit_order_book_matcher_unit.sv
sim/limit_order_book_matcher_unit_tb.sv
